>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top-level RTL file of the position filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/aof_pkg.sv
// ----------------------------------------------------------------------------
// aof_pkg
// Types, constants and helper functions of the position outlier filter.
// ----------------------------------------------------------------------------
package aof_pkg;

  localparam int unsigned SMP_W  = 12;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned PROD_W = SMP_W + POS_W;
  localparam int unsigned IDX_W  = 2;

  localparam logic [SMP_W-1:0] FULL_SCALE = 12'hFFF;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_FILTER_MODE    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FIELD_SIZE     = 2'd1;
  localparam logic [IDX_W-1:0] CFG_PADDLE_SIZE    = 2'd2;
  localparam logic [IDX_W-1:0] CFG_MOVE_THRESHOLD = 2'd3;

  // Reset values.
  localparam logic [SMP_W-1:0] RST_LAST_SAMPLE    = 12'h0FF;
  localparam logic             RST_FILTER_MODE    = 1'b1;
  localparam logic [POS_W-1:0] RST_FIELD_SIZE     = 10'd240;
  localparam logic [POS_W-1:0] RST_PADDLE_SIZE    = 10'd30;
  localparam logic [POS_W-1:0] RST_MOVE_THRESHOLD = 10'd2;

  // Candidate result handed from the window stage to the report stage.
  typedef struct packed {
    logic             direct;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
  } aof_cand_t;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Quotient by 4095: x = q*4096 + lo = q*4095 + (q + lo), and q + lo stays
  // below twice 4095, so a single correction step is enough.
  function automatic logic [POS_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
    logic [POS_W-1:0] q;
    logic [SMP_W:0]   r;
    logic [POS_W:0]   qc;
    q  = x[PROD_W-1:SMP_W];
    r  = {1'b0, x[SMP_W-1:0]} + {3'b000, q};
    qc = {1'b0, q} + {{POS_W{1'b0}}, (r >= {1'b0, FULL_SCALE})};
    return qc[POS_W-1:0];
  endfunction

endpackage

>>> rtl/aof_scaler.sv
// ----------------------------------------------------------------------------
// aof_scaler
// Two-stage sample-to-position scaler: multiply by the span, then divide by
// full scale through a reciprocal-free quotient with one correction.
// ----------------------------------------------------------------------------
module aof_scaler (
  input  logic                        clk,
  input  logic                        ld_mul,
  input  logic                        ld_div,
  input  logic [aof_pkg::POS_W-1:0]   span,
  input  logic [aof_pkg::SMP_W-1:0]   value,
  output logic [aof_pkg::POS_W-1:0]   pos
);
  import aof_pkg::*;

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  always_comb begin
    prod_nxt = value * span;
    pos_nxt  = div_full_scale(prod_r);
  end

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      prod_r <= prod_nxt;
    end
    if (ld_div) begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

>>> rtl/aof_window.sv
// ----------------------------------------------------------------------------
// aof_window
// Three-entry position ring with outlier rejection; produces the candidate
// result of one item (direct pair, or the average of the two closest entries).
// ----------------------------------------------------------------------------
module aof_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ld,
  input  logic                        in_v,
  input  logic                        in_direct,
  input  logic [aof_pkg::POS_W-1:0]   in_pos_old,
  input  logic [aof_pkg::POS_W-1:0]   in_pos_new,
  output logic                        cand_v,
  output aof_pkg::aof_cand_t          cand
);
  import aof_pkg::*;

  logic [POS_W-1:0] ring_r [3];
  logic [1:0]       slot_r, slot_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             cand_v_r, cand_v_nxt;
  aof_cand_t        cand_r, cand_nxt;

  logic [POS_W-1:0] w [3];
  logic [POS_W:0]   d0, d1, d2, best;
  logic [POS_W-1:0] best_v;
  logic [SMP_W-1:0] total;
  logic [SMP_W-1:0] kept;
  logic             take, ring_full;

  assign take      = ld && in_v && !in_direct;
  assign ring_full = (fill_r == 2'd2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = (slot_r == 2'(i)) ? in_pos_new : ring_r[i];
    end
    d0 = {1'b0, abs_diff(w[0], w[1])} + {1'b0, abs_diff(w[0], w[2])};
    d1 = {1'b0, abs_diff(w[1], w[0])} + {1'b0, abs_diff(w[1], w[2])};
    d2 = {1'b0, abs_diff(w[2], w[0])} + {1'b0, abs_diff(w[2], w[1])};
    best   = d0;
    best_v = w[0];
    if (d1 > best) begin
      best   = d1;
      best_v = w[1];
    end
    if (d2 > best) begin
      best_v = w[2];
    end
    // Dropping the first entry equal to the outlier leaves the total minus it.
    total = {2'b00, w[0]} + {2'b00, w[1]} + {2'b00, w[2]};
    kept  = total - {2'b00, best_v};
  end

  always_comb begin
    slot_nxt   = slot_r;
    fill_nxt   = fill_r;
    cand_v_nxt = cand_v_r;
    cand_nxt   = cand_r;
    if (take) begin
      slot_nxt = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
      if (!ring_full) begin
        fill_nxt = fill_r + 2'd1;
      end
    end
    if (ld) begin
      cand_v_nxt = in_v && (in_direct || ring_full);
      cand_nxt.direct = in_direct;
      cand_nxt.pos_a  = in_pos_old;
      cand_nxt.pos_b  = in_direct ? in_pos_new : kept[POS_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= 2'd0;
      fill_r   <= 2'd0;
      cand_v_r <= 1'b0;
    end else begin
      slot_r   <= slot_nxt;
      fill_r   <= fill_nxt;
      cand_v_r <= cand_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    if (take) begin
      ring_r[slot_r] <= in_pos_new;
    end
  end

  assign cand_v = cand_v_r;
  assign cand   = cand_r;

endmodule

>>> rtl/aof_report.sv
// ----------------------------------------------------------------------------
// aof_report
// Result register with the report decision: start position on the first
// filtered report, movement threshold on later ones.
// ----------------------------------------------------------------------------
module aof_report (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ld,
  input  logic                        in_v,
  input  aof_pkg::aof_cand_t          cand,
  input  logic [aof_pkg::POS_W-1:0]   field_size,
  input  logic [aof_pkg::POS_W-1:0]   paddle_size,
  input  logic [aof_pkg::POS_W-1:0]   move_threshold,
  output logic                        out_v,
  output logic [aof_pkg::POS_W-1:0]   out_old,
  output logic [aof_pkg::POS_W-1:0]   out_new
);
  import aof_pkg::*;

  logic [POS_W-1:0] rep_r, rep_nxt;
  logic             first_r, first_nxt;
  logic             out_v_r, out_v_nxt;
  logic [POS_W-1:0] old_r, old_nxt;
  logic [POS_W-1:0] new_r, new_nxt;

  logic [POS_W:0]   need1, need2;
  logic [POS_W-1:0] start;
  logic             emit, take;

  always_comb begin
    need1 = {1'b0, paddle_size} + 11'd1;
    need2 = {1'b0, paddle_size} + 11'd2;
    start = '0;
    if ({1'b0, cand.pos_b} <= need1 && {1'b0, field_size} > need2) begin
      start = POS_W'({1'b0, field_size} - need2);
    end
    emit = cand.direct || !first_r ||
           (abs_diff(cand.pos_b, rep_r) >= move_threshold);
    take = ld && in_v && !cand.direct;
  end

  always_comb begin
    rep_nxt   = rep_r;
    first_nxt = first_r;
    out_v_nxt = out_v_r;
    old_nxt   = old_r;
    new_nxt   = new_r;
    if (take && emit) begin
      rep_nxt   = cand.pos_b;
      first_nxt = 1'b1;
    end
    if (ld) begin
      out_v_nxt = in_v && emit;
      new_nxt   = cand.pos_b;
      priority if (cand.direct) begin
        old_nxt = cand.pos_a;
      end else if (!first_r) begin
        old_nxt = start;
      end else begin
        old_nxt = rep_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r   <= '0;
      first_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      rep_r   <= rep_nxt;
      first_r <= first_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    old_r <= old_nxt;
    new_r <= new_nxt;
  end

  assign out_v   = out_v_r;
  assign out_old = old_r;
  assign out_new = new_r;

endmodule

>>> rtl/adc_position_outlier_filter.sv
// A sample that yields a result shows it on out_valid after stages 1 to 5 below;
// throughput is one sample per cycle while out_stall does not back up the pipeline.
// Repeated samples, ring fill steps and sub-threshold moves yield no result.
// rst_n is synchronous and active low; it restores the register defaults and
// clears the pipeline valids and filter history.
// ----------------------------------------------------------------------------
// adc_position_outlier_filter
// Converts 12-bit converter samples into paddle positions, either directly or
// through a three-sample outlier-rejecting average with a movement threshold.
// ----------------------------------------------------------------------------
//
// Pipeline:
//   stage 1  input register; repeated samples are dropped here and the last
//            sample register is updated on every accepted transaction.
//   stage 2  sample times span, for the current and the previous sample.
//   stage 3  division by full scale (shift plus one correction).
//   stage 4  ring write, outlier pick and average (aof_window).
//   stage 5  report decision and result register (aof_report).
// Each stage loads when it is empty or when the stage after it loads, so
// bubbles collapse and the input keeps taking samples while a finished
// result waits on out_stall, until every stage holds an item. Configuration
// is expected to change only while the pipeline is empty.
`include "assert_macros.svh"

module adc_position_outlier_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [aof_pkg::IDX_W-1:0]   cfg_index,
  input  logic [aof_pkg::POS_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [aof_pkg::SMP_W-1:0]   in_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [aof_pkg::POS_W-1:0]   out_old_position,
  output logic [aof_pkg::POS_W-1:0]   out_new_position
);
  import aof_pkg::*;

  // Configuration registers.
  logic             mode_r, mode_nxt;
  logic [POS_W-1:0] field_r, field_nxt;
  logic [POS_W-1:0] paddle_r, paddle_nxt;
  logic [POS_W-1:0] thresh_r, thresh_nxt;

  // Stage control and payload.
  logic             s1_v_r, s1_v_nxt;
  logic             s1_direct_r;
  logic [SMP_W-1:0] s1_smp_r;
  logic [SMP_W-1:0] s1_old_r;
  logic [SMP_W-1:0] last_sample_r, last_sample_nxt;
  logic             s2_v_r, s2_direct_r;
  logic             s3_v_r, s3_direct_r;
  logic             s4_v;

  logic             en1, en2, en3, en4, en5;
  logic             accept, fresh;
  logic [POS_W:0]   need;
  logic [POS_W-1:0] span;
  logic [POS_W-1:0] pos_new, pos_old;
  aof_cand_t        cand;

  // The user must hold the span fixed while items are in flight, unchecked by the block; stage 2 reads it directly.
  always_comb begin
    need = {1'b0, paddle_r} + 11'd1;
    span = ({1'b0, field_r} > need) ? POS_W'({1'b0, field_r} - need) : '0;
  end

  always_comb begin
    mode_nxt   = mode_r;
    field_nxt  = field_r;
    paddle_nxt = paddle_r;
    thresh_nxt = thresh_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_MODE:    mode_nxt   = cfg_data[0];
        CFG_FIELD_SIZE:     field_nxt  = cfg_data;
        CFG_PADDLE_SIZE:    paddle_nxt = cfg_data;
        CFG_MOVE_THRESHOLD: thresh_nxt = cfg_data;
      endcase
    end
  end

  // Load enables ripple back from the result register.
  always_comb begin
    en5      = !out_valid || !out_stall;
    en4      = !s4_v || en5;
    en3      = !s3_v_r || en4;
    en2      = !s2_v_r || en3;
    en1      = !s1_v_r || en2;
    in_stall = !en1;
  end

  always_comb begin
    accept          = in_valid && en1;
    fresh           = (in_sample != last_sample_r);
    last_sample_nxt = (accept && fresh) ? in_sample : last_sample_r;
    s1_v_nxt        = en1 ? (accept && fresh) : s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= RST_FILTER_MODE;
      field_r       <= RST_FIELD_SIZE;
      paddle_r      <= RST_PADDLE_SIZE;
      thresh_r      <= RST_MOVE_THRESHOLD;
      last_sample_r <= RST_LAST_SAMPLE;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      s3_v_r        <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      field_r       <= field_nxt;
      paddle_r      <= paddle_nxt;
      thresh_r      <= thresh_nxt;
      last_sample_r <= last_sample_nxt;
      s1_v_r        <= s1_v_nxt;
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_smp_r    <= in_sample;
      s1_old_r    <= last_sample_r;
      s1_direct_r <= !mode_r;
    end
    if (en2) begin
      s2_direct_r <= s1_direct_r;
    end
    if (en3) begin
      s3_direct_r <= s2_direct_r;
    end
  end

  aof_scaler u_scale_new (
    .clk    (clk),
    .ld_mul (en2 && s1_v_r),
    .ld_div (en3 && s2_v_r),
    .span   (span),
    .value  (s1_smp_r),
    .pos    (pos_new)
  );

  aof_scaler u_scale_old (
    .clk    (clk),
    .ld_mul (en2 && s1_v_r),
    .ld_div (en3 && s2_v_r),
    .span   (span),
    .value  (s1_old_r),
    .pos    (pos_old)
  );

  aof_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (en4),
    .in_v       (s3_v_r),
    .in_direct  (s3_direct_r),
    .in_pos_old (pos_old),
    .in_pos_new (pos_new),
    .cand_v     (s4_v),
    .cand       (cand)
  );

  aof_report u_report (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld             (en5),
    .in_v           (s4_v),
    .cand           (cand),
    .field_size     (field_r),
    .paddle_size    (paddle_r),
    .move_threshold (thresh_r),
    .out_v          (out_valid),
    .out_old        (out_old_position),
    .out_new        (out_new_position)
  );

  // The input only stalls when every stage holds an item behind a stalled result.
  `ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall,
    s1_v_r && s2_v_r && s3_v_r && s4_v && out_valid && out_stall,
    "input stalled while the pipeline has room")

  // A repeated sample never enters the pipeline.
  `ASSERT_NEXT(a_repeat_dropped, clk, rst_n, accept && !fresh, !s1_v_r,
    "repeated sample entered stage 1")

  // After any accepted transaction the last sample equals that transaction's sample.
  `ASSERT_NEXT(a_last_sample, clk, rst_n, accept, last_sample_r == $past(in_sample),
    "last sample register not tracking accepted samples")

  // A new result only appears when stage 4 held an item.
  `ASSERT_IMPLIES(a_result_source, clk, rst_n, $rose(out_valid), $past(s4_v),
    "result raised without a stage 4 item")

endmodule
